@@ rtl/diff_drive_imu_odometry_defines.svh @@
// assertion macros for the odometry block
`ifndef DIFF_DRIVE_IMU_ODOMETRY_DEFINES_SVH
`define DIFF_DRIVE_IMU_ODOMETRY_DEFINES_SVH

// same-cycle implication, checked outside reset
`define ODO_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("odometry check failed");

// next-cycle implication, checked outside reset
`define ODO_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("odometry check failed");

`endif

@@ rtl/odo_pkg.sv @@
`timescale 1ns / 1ps
package odo_pkg;

  localparam int POS_W       = 48;
  localparam int QFRAC       = 15;
  localparam int TRIG_FRAC   = 15;
  localparam int TRIG_W      = 17;
  localparam int TRIG_MAX    = 65535;
  localparam int TRIG_MIN    = -65536;
  localparam int DPT_W       = 16;
  localparam int DC_W        = 42;
  localparam int ROT_W       = 21;
  localparam int DXY_W       = 48;
  localparam int ACC_W       = 64;
  localparam int MB_W        = 21;
  localparam int DVD_W       = 62;
  localparam int DVS_W       = 34;
  localparam int SPEED_SCALE = 1000000;
  localparam logic [DPT_W-1:0] DPT_RESET = 16'd2196;

  localparam logic OP_CAPTURE = 1'b0;
  localparam logic OP_UPDATE  = 1'b1;

  typedef struct packed {
    logic               opcode;
    logic signed [31:0] left_ticks;
    logic signed [31:0] right_ticks;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
    logic signed [15:0] yaw_rate;
    logic        [31:0] timestamp_us;
  } in_item_t;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [31:0]      speed;
    logic signed [15:0]      heading_z;
    logic signed [15:0]      heading_w;
    logic signed [15:0]      yaw_rate_out;
    logic                    zero_interval;
  } out_item_t;

  typedef struct packed {
    logic start;
    logic accum;
    logic neg;
  } mac_cmd_t;

endpackage

@@ rtl/odo_mac.sv @@
`timescale 1ns / 1ps
module odo_mac import odo_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  mac_cmd_t                cmd_i,
  input  logic signed [ACC_W-1:0] a_i,
  input  logic signed [MB_W-1:0]  b_i,
  output logic                    busy_o,
  output logic signed [ACC_W-1:0] acc_o
);

  localparam int CNT_W = $clog2(MB_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(MB_W - 1);

  logic                    busy_q;
  logic [CNT_W-1:0]        cnt_q;
  logic signed [ACC_W-1:0] a_q;
  logic signed [MB_W-1:0]  b_q;
  logic                    neg_q;
  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic                    sub;

  // the top multiplier bit carries negative weight
  always_comb begin
    sub   = neg_q ^ (cnt_q == LAST);
    acc_d = acc_q;
    if (b_q[0]) begin
      acc_d = sub ? (acc_q - a_q) : (acc_q + a_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (cmd_i.start) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == LAST) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      a_q   <= a_i;
      b_q   <= b_i;
      neg_q <= cmd_i.neg;
      if (!cmd_i.accum) begin
        acc_q <= '0;
      end
    end else if (busy_q) begin
      acc_q <= acc_d;
      a_q   <= a_q <<< 1;
      b_q   <= b_q >>> 1;
    end
  end

  assign busy_o = busy_q;
  assign acc_o  = acc_q;

endmodule

@@ rtl/odo_div.sv @@
`timescale 1ns / 1ps
module odo_div import odo_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             busy_o,
  output logic [DVD_W-1:0] quot_o
);

  localparam int CNT_W = $clog2(DVD_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(DVD_W - 1);

  logic             busy_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DVD_W-1:0] dvd_q, dvd_d;
  logic [DVS_W-1:0] dvs_q;
  logic [DVS_W-1:0] rem_q, rem_d;
  logic [DVS_W:0]   rem_sh, rem_n;
  logic             ge;

  // restoring step, quotient bits shift in behind the dividend
  always_comb begin
    rem_sh = {rem_q, dvd_q[DVD_W-1]};
    ge     = rem_sh >= {1'b0, dvs_q};
    rem_n  = ge ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
    rem_d  = rem_n[DVS_W-1:0];
    dvd_d  = {dvd_q[DVD_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == LAST) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
    end
  end

  assign busy_o = busy_q;
  assign quot_o = dvd_q;

endmodule

@@ rtl/diff_drive_imu_odometry.sv @@
`timescale 1ns / 1ps
// Wheel odometry with IMU heading.
// Input channel in_valid_i / in_stall_o carries one sample item; opcode capture
// stores it as the reference and gives no result, opcode update gives one
// result item on out_valid_o / out_stall_i with position, speed and heading.
// distance_per_tick is written through cfg_we_i / cfg_wdata_i; the user must
// write it only while idle, since the block itself does not enforce this.
// All products run on one shift-add multiply unit, one multiplier bit per
// cycle; speed uses a radix-2 divider, one quotient bit per cycle.
// in_stall_o stays high while a capture or update item is in work, so one
// item is in work at a time.
// A finished result waits in the output register while the next item is
// accepted; if the next result is ready and the register is still held by
// out_stall_i, the block waits before loading it.
// Reset clears position, references (heading 1.0) and sets distance_per_tick
// to 2196; all channels come out of reset empty.
`include "diff_drive_imu_odometry_defines.svh"
module diff_drive_imu_odometry import odo_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_item_t         in_item_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_item_t        out_item_o,
  input  logic             cfg_we_i,
  input  logic [DPT_W-1:0] cfg_wdata_i
);

  typedef enum logic [2:0] {
    P_IDLE, P_LOAD, P_RUN, P_POST, P_DIV, P_FINISH
  } phase_e;

  typedef enum logic [3:0] {
    S_CC, S_CS, S_DC, S_CDT0, S_CDT1, S_SDT0, S_SDT1, S_DX, S_DY,
    S_IX0, S_IX1, S_IY0, S_IY1, S_SPD
  } step_e;

  phase_e phase_q;
  step_e  step_q;

  in_item_t                 in_q;
  out_item_t                out_q;
  logic                     out_valid_q;
  logic [DPT_W-1:0]         dpt_q;
  logic signed [31:0]       ref_left_q, ref_right_q;
  logic [31:0]              ref_time_q;
  logic signed [TRIG_W-1:0] ref_cos_q, ref_sin_q;
  logic signed [POS_W-1:0]  acc_x_q, acc_y_q;
  logic signed [TRIG_W-1:0] cc_q, cs_q;
  logic signed [DC_W-1:0]   dc_q;
  logic signed [ROT_W-1:0]  cdt_q, sdt_q;
  logic signed [DXY_W-1:0]  dx_q, dy_q;
  logic signed [31:0]       spd_q;
  logic                     zero_q;
  logic                     num_neg_q;

  logic signed [15:0]       hz;
  logic signed [31:0]       diff_l, diff_r;
  logic signed [32:0]       dsum;
  logic [31:0]              dt;
  mac_cmd_t                 mac_cmd;
  logic signed [ACC_W-1:0]  mac_a;
  logic signed [MB_W-1:0]   mac_b;
  logic                     mac_busy;
  logic signed [ACC_W-1:0]  mac_acc;
  logic signed [ACC_W-1:0]  num_abs;
  logic signed [ACC_W-1:0]  cos_pre;
  logic                     div_start;
  logic                     div_busy;
  logic [DVD_W-1:0]         div_quot;
  logic signed [31:0]       spd_sat;
  logic                     out_ld;
  logic                     in_acc;

  function automatic logic signed [ACC_W-1:0] rnd_shr(input logic signed [ACC_W-1:0] v,
                                                      input int unsigned s);
    logic signed [ACC_W-1:0] t;
    t = v + $signed(ACC_W'(1) << (s - 1));
    return t >>> s;
  endfunction

  function automatic logic signed [TRIG_W-1:0] clamp_trig(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] r;
    r = v;
    if (v > ACC_W'(TRIG_MAX)) begin
      r = ACC_W'(TRIG_MAX);
    end else if (v < ACC_W'(TRIG_MIN)) begin
      r = ACC_W'(TRIG_MIN);
    end
    return TRIG_W'(r);
  endfunction

  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_stall_o = (phase_q != P_IDLE);
  assign hz         = (in_q.quat_z == 16'sh8000) ? 16'sh7FFF : -in_q.quat_z;
  assign diff_l     = in_q.left_ticks - ref_left_q;
  assign diff_r     = in_q.right_ticks - ref_right_q;
  assign dsum       = 33'(diff_l) + 33'(diff_r);
  assign dt         = in_q.timestamp_us - ref_time_q;
  assign num_abs    = mac_acc[ACC_W-1] ? -mac_acc : mac_acc;
  assign cos_pre    = $signed(ACC_W'(1) << (2 * QFRAC)) - (mac_acc <<< 1);
  assign out_ld     = (phase_q == P_FINISH) && (!out_valid_q || !out_stall_i);
  assign div_start  = (phase_q == P_POST) && (step_q == S_SPD) && (dt != '0);

  // operand selection for the shared multiply unit
  always_comb begin
    mac_cmd.start = (phase_q == P_LOAD);
    mac_cmd.accum = 1'b0;
    mac_cmd.neg   = 1'b0;
    mac_a         = '0;
    mac_b         = '0;
    unique case (step_q)
      S_CC: begin
        mac_a = ACC_W'(hz);
        mac_b = MB_W'(hz);
      end
      S_CS: begin
        mac_a = ACC_W'(hz);
        mac_b = MB_W'(in_q.quat_w);
      end
      S_DC: begin
        mac_a = ACC_W'(dsum);
        mac_b = MB_W'($signed({1'b0, dpt_q}));
      end
      S_CDT0: begin
        mac_a = ACC_W'(ref_cos_q);
        mac_b = MB_W'(cc_q);
      end
      S_CDT1: begin
        mac_a         = ACC_W'(ref_sin_q);
        mac_b         = MB_W'(cs_q);
        mac_cmd.accum = 1'b1;
      end
      S_SDT0: begin
        mac_a = ACC_W'(ref_cos_q);
        mac_b = MB_W'(cs_q);
      end
      S_SDT1: begin
        mac_a         = ACC_W'(ref_sin_q);
        mac_b         = MB_W'(cc_q);
        mac_cmd.accum = 1'b1;
        mac_cmd.neg   = 1'b1;
      end
      S_DX: begin
        mac_a = ACC_W'(dc_q);
        mac_b = cdt_q;
      end
      S_DY: begin
        mac_a = ACC_W'(dc_q);
        mac_b = sdt_q;
      end
      S_IX0: begin
        mac_a = ACC_W'(dx_q);
        mac_b = MB_W'(cc_q);
      end
      S_IX1: begin
        mac_a         = ACC_W'(dy_q);
        mac_b         = MB_W'(cs_q);
        mac_cmd.accum = 1'b1;
        mac_cmd.neg   = 1'b1;
      end
      S_IY0: begin
        mac_a = ACC_W'(dx_q);
        mac_b = MB_W'(cs_q);
      end
      S_IY1: begin
        mac_a         = ACC_W'(dy_q);
        mac_b         = MB_W'(cc_q);
        mac_cmd.accum = 1'b1;
      end
      S_SPD: begin
        mac_a = ACC_W'(dc_q);
        mac_b = MB_W'(SPEED_SCALE);
      end
      default: begin
        mac_a = '0;
        mac_b = '0;
      end
    endcase
  end

  // truncated quotient, then saturate to 32 bits
  always_comb begin
    if (num_neg_q) begin
      spd_sat = (div_quot > DVD_W'(64'd2147483648)) ? 32'sh80000000
                                                     : $signed(32'd0 - div_quot[31:0]);
    end else begin
      spd_sat = (div_quot > DVD_W'(64'd2147483647)) ? 32'sh7FFFFFFF
                                                     : $signed(div_quot[31:0]);
    end
  end

  odo_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (mac_cmd),
    .a_i    (mac_a),
    .b_i    (mac_b),
    .busy_o (mac_busy),
    .acc_o  (mac_acc)
  );

  odo_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (num_abs[DVD_W-1:0]),
    .divisor_i  ({dt, 2'b00}),
    .busy_o     (div_busy),
    .quot_o     (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= P_IDLE;
      step_q      <= S_CC;
      out_valid_q <= 1'b0;
      dpt_q       <= DPT_RESET;
      ref_left_q  <= '0;
      ref_right_q <= '0;
      ref_time_q  <= '0;
      ref_cos_q   <= TRIG_W'(1 << TRIG_FRAC);
      ref_sin_q   <= '0;
      acc_x_q     <= '0;
      acc_y_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        dpt_q <= cfg_wdata_i;
      end
      if (out_ld) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (phase_q)
        P_IDLE: begin
          if (in_valid_i) begin
            phase_q <= P_LOAD;
            step_q  <= S_CC;
          end
        end
        P_LOAD: begin
          phase_q <= P_RUN;
        end
        P_RUN: begin
          if (!mac_busy) begin
            phase_q <= P_POST;
          end
        end
        P_POST: begin
          unique case (step_q)
            S_CS: begin
              if (in_q.opcode == OP_CAPTURE) begin
                ref_left_q  <= in_q.left_ticks;
                ref_right_q <= in_q.right_ticks;
                ref_time_q  <= in_q.timestamp_us;
                ref_cos_q   <= cc_q;
                ref_sin_q   <= clamp_trig(rnd_shr(mac_acc <<< 1, 2 * QFRAC - TRIG_FRAC));
                phase_q     <= P_IDLE;
              end else begin
                step_q  <= S_DC;
                phase_q <= P_LOAD;
              end
            end
            S_IX1: begin
              acc_x_q <= acc_x_q + POS_W'(rnd_shr(mac_acc, TRIG_FRAC + 2));
              step_q  <= S_IY0;
              phase_q <= P_LOAD;
            end
            S_IY1: begin
              acc_y_q <= acc_y_q + POS_W'(rnd_shr(mac_acc, TRIG_FRAC + 2));
              step_q  <= S_SPD;
              phase_q <= P_LOAD;
            end
            S_SPD: begin
              phase_q <= (dt == '0) ? P_FINISH : P_DIV;
            end
            default: begin
              step_q  <= step_e'(step_q + 1'b1);
              phase_q <= P_LOAD;
            end
          endcase
        end
        P_DIV: begin
          if (!div_busy) begin
            phase_q <= P_FINISH;
          end
        end
        P_FINISH: begin
          if (out_ld) begin
            ref_left_q  <= in_q.left_ticks;
            ref_right_q <= in_q.right_ticks;
            ref_time_q  <= in_q.timestamp_us;
            ref_cos_q   <= cc_q;
            ref_sin_q   <= cs_q;
            phase_q     <= P_IDLE;
          end
        end
        default: begin
          phase_q <= P_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_q <= in_item_i;
    end
    if (phase_q == P_POST) begin
      unique case (step_q)
        S_CC:    cc_q  <= clamp_trig(rnd_shr(cos_pre, 2 * QFRAC - TRIG_FRAC));
        S_CS:    cs_q  <= clamp_trig(rnd_shr(mac_acc <<< 1, 2 * QFRAC - TRIG_FRAC));
        S_DC:    dc_q  <= DC_W'(rnd_shr(mac_acc, 8));
        S_CDT1:  cdt_q <= ROT_W'(rnd_shr(mac_acc, TRIG_FRAC));
        S_SDT1:  sdt_q <= ROT_W'(rnd_shr(mac_acc, TRIG_FRAC));
        S_DX:    dx_q  <= DXY_W'(rnd_shr(mac_acc, TRIG_FRAC));
        S_DY:    dy_q  <= DXY_W'(rnd_shr(mac_acc, TRIG_FRAC));
        S_SPD: begin
          num_neg_q <= mac_acc[ACC_W-1];
          spd_q     <= '0;
          zero_q    <= (dt == '0);
        end
        default: begin
        end
      endcase
    end
    if (phase_q == P_DIV && !div_busy) begin
      spd_q <= spd_sat;
    end
    if (out_ld) begin
      out_q.pos_x         <= acc_x_q;
      out_q.pos_y         <= acc_y_q;
      out_q.speed         <= spd_q;
      out_q.heading_z     <= hz;
      out_q.heading_w     <= in_q.quat_w;
      out_q.yaw_rate_out  <= in_q.yaw_rate;
      out_q.zero_interval <= zero_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `ODO_ASSERT(a_idle_units, !in_stall_o, !mac_busy && !div_busy)
  `ODO_ASSERT(a_one_unit, mac_busy, !div_busy)
  `ODO_ASSERT_NXT(a_busy_after_take, in_valid_i && !in_stall_o, in_stall_o)

endmodule

@@ dv/tb_diff_drive_imu_odometry.sv @@
`timescale 1ns / 1ps
module tb_diff_drive_imu_odometry;
  import odo_pkg::*;

  class odo_scoreboard;
    logic [15:0] dist_per_tick;
    logic [31:0] base_left, base_right, base_time;
    longint base_cos, base_sin;
    logic [47:0] pos_x_q, pos_y_q;
    out_item_t pending_q[$];
    int unsigned mismatches;
    int unsigned results_seen;

    function new();
      dist_per_tick = DPT_RESET;
      base_left = '0;
      base_right = '0;
      base_time = '0;
      base_cos = 64'sd32768;
      base_sin = 0;
      pos_x_q = '0;
      pos_y_q = '0;
      mismatches = 0;
      results_seen = 0;
    endfunction

    function longint round_shift(longint v, int s);
      longint t;
      t = v + (64'sd1 <<< (s - 1));
      return t >>> s;
    endfunction

    function longint clamp_trig(longint v);
      if (v > TRIG_MAX) return TRIG_MAX;
      if (v < TRIG_MIN) return TRIG_MIN;
      return v;
    endfunction

    function void note_item(in_item_t it);
      longint hz, qw, cc, cs, dc, cdt, sdt, dx, dy, incx, incy, spd, dsum;
      logic [31:0] dt, dl, dr;
      out_item_t exp_item;
      hz = (it.quat_z == 16'sh8000) ? 32767 : -longint'(it.quat_z);
      qw = longint'(it.quat_w);
      cc = clamp_trig(round_shift((64'sd1 <<< 30) - 2 * hz * hz, 15));
      cs = clamp_trig(round_shift(2 * hz * qw, 15));
      if (it.opcode == OP_UPDATE) begin
        dl = it.left_ticks - base_left;
        dr = it.right_ticks - base_right;
        dsum = longint'($signed(dl)) + longint'($signed(dr));
        dc = round_shift(dsum * longint'({1'b0, dist_per_tick}), 8);
        cdt = round_shift(base_cos * cc + base_sin * cs, 15);
        sdt = round_shift(cs * base_cos - cc * base_sin, 15);
        dx = round_shift(cdt * dc, 15);
        dy = round_shift(sdt * dc, 15);
        incx = round_shift(cc * dx - cs * dy, 17);
        incy = round_shift(cs * dx + cc * dy, 17);
        pos_x_q = pos_x_q + incx[47:0];
        pos_y_q = pos_y_q + incy[47:0];
        dt = it.timestamp_us - base_time;
        exp_item.zero_interval = (dt == 0);
        if (dt == 0) begin
          spd = 0;
        end else begin
          spd = (dc * 1000000) / (longint'({1'b0, dt}) * 4);
          if (spd > 64'sd2147483647) spd = 64'sd2147483647;
          if (spd < -64'sd2147483648) spd = -64'sd2147483648;
        end
        exp_item.pos_x = pos_x_q;
        exp_item.pos_y = pos_y_q;
        exp_item.speed = spd[31:0];
        exp_item.heading_z = hz[15:0];
        exp_item.heading_w = it.quat_w;
        exp_item.yaw_rate_out = it.yaw_rate;
        pending_q.push_back(exp_item);
      end
      base_left = it.left_ticks;
      base_right = it.right_ticks;
      base_time = it.timestamp_us;
      base_cos = cc;
      base_sin = cs;
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      results_seen++;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item %p", got);
        return;
      end
      want = pending_q.pop_front();
      if (got.pos_x !== want.pos_x || got.pos_y !== want.pos_y ||
          got.speed !== want.speed || got.heading_z !== want.heading_z ||
          got.heading_w !== want.heading_w || got.yaw_rate_out !== want.yaw_rate_out ||
          got.zero_interval !== want.zero_interval) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_item_t in_item_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b1;
  out_item_t out_item_o;
  logic cfg_we_i = 1'b0;
  logic [DPT_W-1:0] cfg_wdata_i = '0;

  odo_scoreboard odo_sb;
  bit stim_done = 1'b0;
  bit hold_sink = 1'b0;
  int unsigned idle_cycles = 0;
  int unsigned items_sent = 0;
  logic [31:0] cur_left, cur_right, cur_time;

  always #2 clk_i = ~clk_i;

  diff_drive_imu_odometry u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_item_i(in_item_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_item_o(out_item_o),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i)
  );

  function int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(20, 600);
  endfunction

  // valid stays up between back-to-back items, drops only for a gap
  task automatic send_item(in_item_t it);
    int unsigned g;
    g = gap_len();
    if (g != 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    odo_sb.note_item(it);
    items_sent++;
  endtask

  task automatic stop_input();
    in_valid_i <= 1'b0;
  endtask

  task automatic write_dpt(logic [15:0] v);
    stop_input();
    while (odo_sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (500) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    odo_sb.dist_per_tick = v;
  endtask

  function automatic in_item_t make_item(logic op, logic [31:0] l, logic [31:0] r,
                                         logic [15:0] z, logic [15:0] w,
                                         logic [15:0] yr, logic [31:0] t);
    in_item_t it;
    it.opcode = op;
    it.left_ticks = l;
    it.right_ticks = r;
    it.quat_z = z;
    it.quat_w = w;
    it.yaw_rate = yr;
    it.timestamp_us = t;
    return it;
  endfunction

  function automatic in_item_t motion_item(logic op);
    int unsigned mode;
    logic [31:0] step_t;
    mode = $urandom_range(0, 9);
    if (mode == 0) begin
      cur_left = $urandom;
      cur_right = $urandom;
      cur_time = $urandom;
    end else begin
      cur_left = cur_left + 32'($signed($urandom_range(0, 4000)) - 2000);
      cur_right = cur_right + 32'($signed($urandom_range(0, 4000)) - 2000);
      step_t = (mode == 1) ? 32'd0 : $urandom_range(1, 200000);
      cur_time = cur_time + step_t;
    end
    return make_item(op, cur_left, cur_right, 16'($urandom), 16'($urandom),
                     16'($urandom), cur_time);
  endfunction

  task automatic random_phase(int unsigned n);
    repeat (n) send_item(motion_item(($urandom_range(0, 4) == 0) ? OP_CAPTURE : OP_UPDATE));
  endtask

  // result side
  initial begin
    int unsigned g;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) odo_sb.check_result(out_item_o);
      if (hold_sink) begin
        out_stall_i <= 1'b1;
      end else begin
        g = gap_len();
        out_stall_i <= (g != 0 && $urandom_range(0, 1) == 0);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
        $display("tb_diff_drive_imu_odometry: errors");
        $finish;
      end
    end
  end

  initial begin
    odo_sb = new();
    cur_left = 0;
    cur_right = 0;
    cur_time = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // update without capture uses the reset reference
    send_item(make_item(OP_UPDATE, 32'd1000, 32'd1200, 16'sd0, 16'sd32767, 16'sd5, 32'd1000));
    send_item(make_item(OP_CAPTURE, 32'h7fffffff, 32'h80000000, 16'h8000, 16'h7fff,
                        16'h8000, 32'hffffffff));
    send_item(make_item(OP_UPDATE, 32'h80000000, 32'h7fffffff, 16'h7fff, 16'h8000,
                        16'h7fff, 32'hffffffff));
    send_item(make_item(OP_UPDATE, 32'h80001000, 32'h7ffff000, 16'h8000, 16'h8000,
                        16'h0000, 32'h00000000));
    send_item(make_item(OP_UPDATE, 32'hffffffff, 32'h00000000, 16'h5a82, 16'h5a82,
                        16'hffff, 32'h00000001));
    send_item(make_item(OP_UPDATE, 32'h7fffffff, 32'h7fffffff, 16'h0000, 16'h7fff,
                        16'h1234, 32'h00000002));
    send_item(make_item(OP_CAPTURE, 32'd0, 32'd0, 16'h4000, 16'h6ed9, 16'h0, 32'd10));
    send_item(make_item(OP_UPDATE, 32'd500, 32'd300, 16'hc000, 16'h6ed9, 16'h0, 32'd10));
    write_dpt(16'd0);
    send_item(make_item(OP_UPDATE, 32'd90000, 32'd80000, 16'h1000, 16'h7000, 16'h1, 32'd500));
    write_dpt(16'hffff);
    send_item(make_item(OP_UPDATE, 32'h70000000, 32'h70000000, 16'h0, 16'h7fff, 16'h2, 32'd501));
    send_item(make_item(OP_UPDATE, 32'h90000000, 32'h90000000, 16'h0, 16'h7fff, 16'h3, 32'd502));
    write_dpt(16'd1);
    random_phase(150);
    // long receiver hold while the sender keeps going
    fork
      begin
        hold_sink = 1'b1;
        repeat (3000) @(posedge clk_i);
        hold_sink = 1'b0;
      end
      random_phase(20);
    join
    write_dpt(16'd2196);
    random_phase(250);
    write_dpt(16'h8000);
    random_phase(150);
    write_dpt(16'hffff);
    random_phase(150);
    stop_input();
    stim_done = 1'b1;
    while (odo_sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (500) @(posedge clk_i);
    $display("covered %0d items, %0d results, several tick scales incl. extremes",
             items_sent, odo_sb.results_seen);
    $display("mismatches counted: %0d", odo_sb.mismatches);
    if (odo_sb.mismatches == 0 && odo_sb.pending_q.size() == 0) begin
      $display("tb_diff_drive_imu_odometry: clean");
    end else begin
      $display("tb_diff_drive_imu_odometry: errors");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/odo_pkg.sv
rtl/odo_mac.sv
rtl/odo_div.sv
rtl/diff_drive_imu_odometry.sv
dv/tb_diff_drive_imu_odometry.sv
